/* src/fhc_pkg.sv */
// free hole cache: shared types and constants
// used by fhc_store, fhc_match and free_hole_cache_unit; no dependencies
`default_nettype none

package fhc_pkg;

  localparam int unsigned OFFSET_W           = 64;
  localparam int unsigned LEN_W              = 15;
  localparam int unsigned MODE_W             = 2;
  localparam int unsigned MAX_ENTRIES_DEF    = 8;
  localparam int unsigned BIG_BLOCK_BITS_DEF = 23;
  localparam logic [LEN_W-1:0] MIN_KEPT_LEN  = 15'd128;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIND  = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_CLEAN = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EVAL = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] start;
    logic [LEN_W-1:0]    len;
  } entry_t;

  typedef struct packed {
    logic                fit;    // request fits the entry (find)
    logic                keep;   // entry lies outside the cleaned big block
    logic [OFFSET_W-1:0] new_start;
    logic [LEN_W-1:0]    new_len;
  } match_t;

endpackage

`default_nettype wire

/* src/fhc_store.sv */
// free hole cache: extent table memory, one write and one registered read port
// depends on fhc_pkg
`default_nettype none

module fhc_store #(
  parameter int unsigned MAX_ENTRIES = fhc_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic           clk,
  input  wire logic           wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire fhc_pkg::entry_t  wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output fhc_pkg::entry_t     rd_data
);

  fhc_pkg::entry_t mem [MAX_ENTRIES];
  fhc_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* src/fhc_match.sv */
// free hole cache: shared compare and advance unit applied to one entry a step
// depends on fhc_pkg
`default_nettype none

module fhc_match #(
  parameter int unsigned BIG_BLOCK_BITS = fhc_pkg::BIG_BLOCK_BITS_DEF
) (
  input  wire fhc_pkg::entry_t              entry,
  input  wire logic [fhc_pkg::LEN_W-1:0]    req_len,
  input  wire logic [fhc_pkg::OFFSET_W-1:0] where,
  output fhc_pkg::match_t                 res
);

  localparam int unsigned BASE_W = fhc_pkg::OFFSET_W - BIG_BLOCK_BITS;

  logic [BASE_W-1:0] entry_base;
  logic [BASE_W-1:0] where_base;

  assign entry_base = entry.start[fhc_pkg::OFFSET_W-1:BIG_BLOCK_BITS];
  assign where_base = where[fhc_pkg::OFFSET_W-1:BIG_BLOCK_BITS];

  always_comb begin
    res.fit       = (req_len <= entry.len);
    res.keep      = (entry_base != where_base);
    // start wraps modulo 2^64
    res.new_start = entry.start + {{(fhc_pkg::OFFSET_W-fhc_pkg::LEN_W){1'b0}}, req_len};
    res.new_len   = entry.len - req_len;
  end

endmodule

`default_nettype wire

/* src/free_hole_cache_unit.sv */
// free hole cache: top level with the scan sequencer and result register
// depends on fhc_pkg, fhc_store, fhc_match
//
// usage: one request beat on in_* (mode in in_tuser, offset and length in
// in_tdata) gives exactly one result beat on out_* (found in out_tuser,
// granted offset in out_tdata; zero unless a find succeeded).
// the extents sit in a circular table, oldest at the head pointer. find and
// clean walk the table one entry at a time through a single read port and a
// single compare/advance unit; each visited entry passes through a read state
// and an evaluate state. a find stops at the first fitting entry.
// add and unused modes go from idle straight to the result state; find
// reaches it at a fit or at the end of the table, clean at the end of the
// table. in_tready is high only while the sequencer is idle. the result
// waits in an output register, so a new request is taken while an earlier
// result is still unclaimed; if out_tready stays low the sequencer holds the
// next result until the register frees.
// reset (rst_n low, synchronous) empties the table, clears the head pointer
// and drops any pending result; no clearing pass is needed.
`default_nettype none

module free_hole_cache_unit #(
  parameter int unsigned MAX_ENTRIES    = fhc_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned BIG_BLOCK_BITS = fhc_pkg::BIG_BLOCK_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // [63:0] offset, [78:64] length, [79] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] hole_offset
  output logic             out_tuser   // [0] found
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  fhc_pkg::state_t                state_r, state_nxt;
  fhc_pkg::mode_t                 mode_r, mode_nxt;
  logic [fhc_pkg::OFFSET_W-1:0]   offset_r, offset_nxt;
  logic [fhc_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [IDX_W-1:0]               head_r, head_nxt;
  logic [CNT_W-1:0]               idx_r, idx_nxt;
  logic [CNT_W-1:0]               wr_r, wr_nxt;
  logic                           found_r, found_nxt;
  logic [fhc_pkg::OFFSET_W-1:0]   hole_r, hole_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           found_out_r, found_out_nxt;
  logic [fhc_pkg::OFFSET_W-1:0]   hole_out_r, hole_out_nxt;

  logic                           in_fire;
  fhc_pkg::mode_t                 in_mode;
  logic [fhc_pkg::OFFSET_W-1:0]   in_offset;
  logic [fhc_pkg::LEN_W-1:0]      in_length;

  logic                           mem_we;
  logic [CNT_W-1:0]               wr_ptr;
  logic [SUM_W-1:0]               wr_sum, rd_sum;
  logic [IDX_W-1:0]               wr_slot, rd_slot;
  fhc_pkg::entry_t                wr_entry, rd_entry;
  fhc_pkg::match_t                match;
  logic                           head_last;

  assign in_mode   = fhc_pkg::mode_t'(in_tuser);
  assign in_offset = in_tdata[63:0];
  assign in_length = in_tdata[78:64];
  assign in_tready = (state_r == fhc_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // logical position -> physical slot, relative to the oldest entry
  always_comb begin
    rd_sum = SUM_W'(head_r) + SUM_W'(idx_r);
    if (rd_sum >= SUM_W'(MAX_ENTRIES)) begin
      rd_sum = rd_sum - SUM_W'(MAX_ENTRIES);
    end
    wr_sum = SUM_W'(head_r) + SUM_W'(wr_ptr);
    if (wr_sum >= SUM_W'(MAX_ENTRIES)) begin
      wr_sum = wr_sum - SUM_W'(MAX_ENTRIES);
    end
  end

  assign rd_slot   = rd_sum[IDX_W-1:0];
  assign wr_slot   = wr_sum[IDX_W-1:0];
  assign head_last = (head_r == IDX_W'(MAX_ENTRIES - 1));

  fhc_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_slot),
    .wr_data (wr_entry),
    .rd_addr (rd_slot),
    .rd_data (rd_entry)
  );

  fhc_match #(
    .BIG_BLOCK_BITS (BIG_BLOCK_BITS)
  ) u_match (
    .entry   (rd_entry),
    .req_len (len_r),
    .where   (offset_r),
    .res     (match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fhc_pkg::ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    offset_r    <= offset_nxt;
    len_r       <= len_nxt;
    idx_r       <= idx_nxt;
    wr_r        <= wr_nxt;
    found_r     <= found_nxt;
    hole_r      <= hole_nxt;
    found_out_r <= found_out_nxt;
    hole_out_r  <= hole_out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    offset_nxt    = offset_r;
    len_nxt       = len_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    idx_nxt       = idx_r;
    wr_nxt        = wr_r;
    found_nxt     = found_r;
    hole_nxt      = hole_r;
    found_out_nxt = found_out_r;
    hole_out_nxt  = hole_out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    wr_ptr        = idx_r;
    wr_entry      = rd_entry;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      fhc_pkg::ST_IDLE: begin
        if (in_fire) begin
          mode_nxt   = in_mode;
          offset_nxt = in_offset;
          len_nxt    = in_length;
          idx_nxt    = '0;
          wr_nxt     = '0;
          found_nxt  = 1'b0;
          hole_nxt   = '0;
          case (in_mode)
            fhc_pkg::MODE_FIND,
            fhc_pkg::MODE_CLEAN: begin
              state_nxt = fhc_pkg::ST_READ;
            end
            fhc_pkg::MODE_ADD: begin
              state_nxt      = fhc_pkg::ST_DONE;
              wr_entry.start = in_offset;
              wr_entry.len   = in_length;
              if (in_length > fhc_pkg::MIN_KEPT_LEN) begin
                mem_we = 1'b1;
                if (count_r < CNT_W'(MAX_ENTRIES)) begin
                  wr_ptr    = count_r;
                  count_nxt = count_r + CNT_W'(1);
                end else begin
                  // table full: overwrite the oldest and move the head on
                  wr_ptr   = '0;
                  head_nxt = head_last ? '0 : head_r + IDX_W'(1);
                end
              end
            end
            default: begin
              state_nxt = fhc_pkg::ST_DONE;
            end
          endcase
        end
      end

      fhc_pkg::ST_READ: begin
        if (idx_r >= count_r) begin
          if (mode_r == fhc_pkg::MODE_CLEAN) begin
            count_nxt = wr_r;
          end
          state_nxt = fhc_pkg::ST_DONE;
        end else begin
          state_nxt = fhc_pkg::ST_EVAL;
        end
      end

      fhc_pkg::ST_EVAL: begin
        idx_nxt   = idx_r + CNT_W'(1);
        state_nxt = fhc_pkg::ST_READ;
        if (mode_r == fhc_pkg::MODE_FIND) begin
          if (match.fit) begin
            mem_we         = 1'b1;
            wr_ptr         = idx_r;
            wr_entry.start = match.new_start;
            wr_entry.len   = match.new_len;
            found_nxt      = 1'b1;
            hole_nxt       = rd_entry.start;
            state_nxt      = fhc_pkg::ST_DONE;
          end
        end else begin
          // compaction: survivors move down to the write position
          if (match.keep) begin
            mem_we   = 1'b1;
            wr_ptr   = wr_r;
            wr_entry = rd_entry;
            wr_nxt   = wr_r + CNT_W'(1);
          end
        end
      end

      fhc_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          found_out_nxt = found_r;
          hole_out_nxt  = hole_r;
          state_nxt     = fhc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = fhc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = hole_out_r;
  assign out_tuser  = found_out_r;

endmodule

`default_nettype wire
